// ===== design/fmprf_pkg.sv =====
`timescale 1ns / 1ps
// Package for the first-match packet rule filter: request/response structs,
// the token that walks the cell chain, opcode and rule kind codes. No dependencies.
package fmprf_pkg;

  localparam int RULE_SLOTS_DEF = 32;
  localparam int RULE_SLOTS_MAX = 256;

  // token widths cover the largest table size
  localparam int TOK_IDX_W = $clog2(RULE_SLOTS_MAX);
  localparam int TOK_CNT_W = $clog2(RULE_SLOTS_MAX + 1);

  localparam logic [1:0] OP_CLASSIFY = 2'd0;
  localparam logic [1:0] OP_APPEND   = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;

  localparam logic [1:0] KIND_PROTO  = 2'd0;
  localparam logic [1:0] KIND_PORT   = 2'd1;
  localparam logic [1:0] KIND_SRC_IP = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        packet_valid;
    logic [7:0]  protocol;
    logic [15:0] dest_port;
    logic [31:0] src_ip;
    logic [1:0]  rule_kind;
    logic [31:0] rule_value;
    logic [4:0]  rule_slot;
  } in_req_t;

  typedef struct packed {
    logic        drop;
    logic        matched;
    logic [4:0]  match_index;
    logic [31:0] hit_count;
    logic [5:0]  rule_count;
    logic        status;
  } out_rsp_t;

  // one request in flight through the cell row
  typedef struct packed {
    logic [1:0]           opcode;
    logic                 pkt_ok;
    logic [7:0]           protocol;
    logic [15:0]          dest_port;
    logic [31:0]          src_ip;
    logic [1:0]           rule_kind;
    logic [31:0]          rule_value;
    logic [4:0]           rule_slot;
    logic [TOK_CNT_W-1:0] limit;
    logic                 found;
    logic [TOK_IDX_W-1:0] index;
    logic [31:0]          hits;
    logic                 status;
    logic [5:0]           rule_count;
  } tok_t;

endpackage

// ===== design/fmprf_cell.sv =====
`timescale 1ns / 1ps
// One rule slot of the filter: stored rule, hit counter and a token stage.
// Depends on fmprf_pkg.
module fmprf_cell
  import fmprf_pkg::*;
#(
  parameter int CELL_IDX = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_vld,
  input  tok_t in_tok,
  output logic out_vld,
  output tok_t out_tok
);

  logic [1:0]  kind_r;
  logic [31:0] value_r;
  logic [31:0] hits_r;
  logic        vld_r;
  tok_t        tok_r;
  tok_t        tok_nxt;

  logic in_range;
  logic kind_hit;
  logic match;
  logic append_here;
  logic read_here;

  assign in_range = TOK_CNT_W'(CELL_IDX) < in_tok.limit;

  always_comb begin
    case (kind_r)
      KIND_PROTO:  kind_hit = value_r == 32'(in_tok.protocol);
      KIND_PORT:   kind_hit = value_r == 32'(in_tok.dest_port);
      KIND_SRC_IP: kind_hit = value_r == in_tok.src_ip;
      default:     kind_hit = 1'b0;
    endcase
  end

  assign match = in_vld && in_tok.opcode == OP_CLASSIFY && in_tok.pkt_ok
                 && !in_tok.found && in_range && kind_hit;
  assign append_here = in_vld && in_tok.opcode == OP_APPEND && !in_tok.status
                       && in_tok.limit == TOK_CNT_W'(CELL_IDX);
  assign read_here = in_vld && in_tok.opcode == OP_READ && in_range
                     && TOK_CNT_W'(in_tok.rule_slot) == TOK_CNT_W'(CELL_IDX);

  always_comb begin
    tok_nxt = in_tok;
    if (match) begin
      tok_nxt.found = 1'b1;
      tok_nxt.index = TOK_IDX_W'(CELL_IDX);
    end
    if (read_here) begin
      tok_nxt.hits = hits_r;
    end
  end

  // rule storage, undefined until appended
  always_ff @(posedge clk) begin
    if (append_here) begin
      kind_r  <= in_tok.rule_kind;
      value_r <= in_tok.rule_value;
      hits_r  <= '0;
    end else if (match && !(&hits_r)) begin
      hits_r  <= hits_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign out_vld = vld_r;
  assign out_tok = tok_r;

endmodule

// ===== design/first_match_packet_rule_filter.sv =====
`timescale 1ns / 1ps
// Top level of the first-match packet rule filter: entry logic, rule count,
// and a row of fmprf_cell stages. Depends on fmprf_pkg and fmprf_cell.
//
//   channel  | ports                   | handshake
//   ---------+-------------------------+-----------------------------------
//   request  | start, busy, in_req     | taken when start=1 and busy=0
//   result   | out_valid, out_rsp      | one-cycle strobe, no backpressure
//
// A request walks the cell row, one registered cell per rule slot; its result is
// strobed as it leaves the last cell, and the next request can be taken in
// that same cycle, so only one request is in the row at a time.
// The row length is set by RULE_SLOTS, one cell per rule slot.
// Reset (rst_n low, synchronous) empties the table and drops any request in
// flight; rule contents are not cleared, only the rule count.
// The result side cannot stall; busy is the only flow control.
module first_match_packet_rule_filter
  import fmprf_pkg::*;
#(
  parameter int RULE_SLOTS = RULE_SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_rsp_t out_rsp
);

  localparam int CNT_W = $clog2(RULE_SLOTS + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             busy_r;
  logic             busy_nxt;
  logic             accept;
  logic             table_full;
  tok_t             entry_tok;

  // token chain: index 0 feeds cell 0, index RULE_SLOTS leaves the last cell
  logic [RULE_SLOTS:0] chain_vld;
  tok_t                chain_tok [RULE_SLOTS+1];
  tok_t                last_tok;

  assign accept     = start && !busy_r;
  assign table_full = count_r >= CNT_W'(RULE_SLOTS);

  // append bumps the count right away; the slot write happens in its cell
  // before the next request can enter the row
  always_comb begin
    count_nxt = count_r;
    if (accept && in_req.opcode == OP_APPEND && !table_full) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  // build the request token; status is settled here from the count
  always_comb begin
    entry_tok            = '0;
    entry_tok.opcode     = in_req.opcode;
    entry_tok.pkt_ok     = in_req.packet_valid;
    entry_tok.protocol   = in_req.protocol;
    entry_tok.dest_port  = in_req.dest_port;
    entry_tok.src_ip     = in_req.src_ip;
    entry_tok.rule_kind  = in_req.rule_kind;
    entry_tok.rule_slot  = in_req.rule_slot;
    entry_tok.limit      = TOK_CNT_W'(count_r);
    entry_tok.rule_count = 6'(count_nxt);
    case (in_req.rule_kind)
      KIND_PROTO: entry_tok.rule_value = {24'd0, in_req.rule_value[7:0]};
      KIND_PORT:  entry_tok.rule_value = {16'd0, in_req.rule_value[15:0]};
      default:    entry_tok.rule_value = in_req.rule_value;
    endcase
    case (in_req.opcode)
      OP_APPEND: entry_tok.status = table_full;
      OP_READ:   entry_tok.status = TOK_CNT_W'(in_req.rule_slot) >= TOK_CNT_W'(count_r);
      default:   entry_tok.status = 1'b0;
    endcase
  end

  assign chain_vld[0] = accept;
  assign chain_tok[0] = entry_tok;

  for (genvar i = 0; i < RULE_SLOTS; i++) begin : g_cell
    fmprf_cell #(
      .CELL_IDX(i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .in_vld (chain_vld[i]),
      .in_tok (chain_tok[i]),
      .out_vld(chain_vld[i+1]),
      .out_tok(chain_tok[i+1])
    );
  end

  // busy drops in the cycle the result is strobed
  assign busy_nxt = (accept || busy_r) && !chain_vld[RULE_SLOTS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      busy_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy     = busy_r;
  assign last_tok = chain_tok[RULE_SLOTS];

  assign out_valid           = chain_vld[RULE_SLOTS];
  assign out_rsp.drop        = last_tok.found;
  assign out_rsp.matched     = last_tok.found;
  assign out_rsp.match_index = last_tok.index[4:0];
  assign out_rsp.hit_count   = last_tok.hits;
  assign out_rsp.rule_count  = last_tok.rule_count;
  assign out_rsp.status      = last_tok.status;

  // at most one request in the row
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(chain_vld[RULE_SLOTS:1]))
    else $error("more than one request in the cell row");

  // the rule count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(RULE_SLOTS))
    else $error("rule count beyond table size");

  // a taken request keeps the block busy or has its result strobed next
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy_r || out_valid))
    else $error("request taken but block neither busy nor responding");

  // a flagged status never comes with a rule match
  a_status_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status) |-> !out_rsp.matched)
    else $error("status and match both set");

endmodule

// ===== tb/fmprf_scoreboard.sv =====
`timescale 1ns / 1ps
// Scoreboard for first_match_packet_rule_filter: watches the request and result
// channels, predicts each response from its own rule table and compares it.
// Depends on fmprf_pkg.
module fmprf_scoreboard
  import fmprf_pkg::*;
#(
  parameter int RULE_SLOTS = RULE_SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  in_req_t  in_req,
  input  logic     out_valid,
  input  out_rsp_t out_rsp,
  output int       errors,
  output int       outstanding
);

  logic [1:0]  kind_tbl [RULE_SLOTS];
  logic [31:0] value_tbl[RULE_SLOTS];
  logic [31:0] hits_tbl [RULE_SLOTS];
  int          rules_held;
  out_rsp_t    expected_rsp_q[$];

  // Response to one request; updates the rule table and hit counters.
  function automatic out_rsp_t filter_response(in_req_t req);
    out_rsp_t   rsp;
    logic       hit;
    logic [31:0] val;
    rsp = '0;
    case (req.opcode)
      OP_CLASSIFY: if (req.packet_valid) begin
        for (int i = 0; i < rules_held && i < RULE_SLOTS; i++) begin
          case (kind_tbl[i])
            KIND_PROTO:  hit = value_tbl[i] == {24'd0, req.protocol};
            KIND_PORT:   hit = value_tbl[i] == {16'd0, req.dest_port};
            KIND_SRC_IP: hit = value_tbl[i] == req.src_ip;
            default:     hit = 1'b0;
          endcase
          if (hit && !rsp.matched) begin
            if (hits_tbl[i] != '1) hits_tbl[i] = hits_tbl[i] + 32'd1;
            rsp.drop        = 1'b1;
            rsp.matched     = 1'b1;
            rsp.match_index = 5'(i);
          end
        end
      end
      OP_APPEND: if (rules_held >= RULE_SLOTS) begin
        rsp.status = 1'b1;
      end else begin
        val = req.rule_value;
        if (req.rule_kind == KIND_PROTO) val = {24'd0, val[7:0]};
        else if (req.rule_kind == KIND_PORT) val = {16'd0, val[15:0]};
        kind_tbl[rules_held]  = req.rule_kind;
        value_tbl[rules_held] = val;
        hits_tbl[rules_held]  = '0;
        rules_held++;
      end
      OP_READ: if (int'(req.rule_slot) < rules_held && int'(req.rule_slot) < RULE_SLOTS) begin
        rsp.hit_count = hits_tbl[req.rule_slot];
      end else begin
        rsp.status = 1'b1;
      end
      default: ;
    endcase
    rsp.rule_count = 6'(rules_held);
    return rsp;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_rsp_t want;
    if (!rst_n) begin
      rules_held = 0;
      expected_rsp_q.delete();
    end else begin
      // the result strobed at this edge belongs to an earlier request
      if (out_valid) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response with no request outstanding: %p", out_rsp);
          errors++;
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("drop",        32'(want.drop),        32'(out_rsp.drop));
          check_field("matched",     32'(want.matched),     32'(out_rsp.matched));
          check_field("match_index", 32'(want.match_index), 32'(out_rsp.match_index));
          check_field("hit_count",   want.hit_count,        out_rsp.hit_count);
          check_field("rule_count",  32'(want.rule_count),  32'(out_rsp.rule_count));
          check_field("status",      32'(want.status),      32'(out_rsp.status));
        end
      end
      if (start && !busy) expected_rsp_q.push_back(filter_response(in_req));
    end
    outstanding <= expected_rsp_q.size();
  end

endmodule

// ===== tb/first_match_packet_rule_filter_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for first_match_packet_rule_filter: drives directed and random
// requests and gives the verdict. Depends on fmprf_pkg and fmprf_scoreboard.
module first_match_packet_rule_filter_tb;
  import fmprf_pkg::*;

  localparam int RULE_SLOTS      = RULE_SLOTS_DEF;
  localparam int RANDOM_REQUESTS = 950;
  localparam int MAX_GAP         = 10;
  // well above the slowest run: ~1000 requests, each with row walk, longest gap and wait for busy
  localparam int CYCLE_LIMIT     = 400000;

  // codes outside the defined sets; the block must treat them as no-ops / no-match
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_req_t  in_req;
  logic     out_valid;
  out_rsp_t out_rsp;

  int errors;
  int outstanding;
  int cycle_count = 0;
  bit gaps_on;

  // rules appended so far, kept only to aim packets, reads and duplicate appends at them
  logic [1:0]  sent_kinds[$];
  logic [31:0] sent_values[$];

  always #5 clk = ~clk;

  first_match_packet_rule_filter #(
    .RULE_SLOTS(RULE_SLOTS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  fmprf_scoreboard #(
    .RULE_SLOTS(RULE_SLOTS)
  ) scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_rsp    (out_rsp),
    .errors     (errors),
    .outstanding(outstanding)
  );

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic in_req_t blank_request(logic [1:0] op);
    in_req_t req;
    req        = '0;
    req.opcode = op;
    return req;
  endfunction

  // Sends one request. Called at a rising edge; returns at the edge where it
  // was taken, with start still high so back-to-back requests keep it up.
  task automatic issue(input in_req_t req);
    int          gap;
    logic [31:0] val;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      // half the time the gap starts once busy drops, so it spans the
      // ready window instead of hiding in the row walk
      if ($urandom_range(0, 1)) begin
        @(posedge clk);
        while (busy) @(posedge clk);
      end
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (req.opcode == OP_APPEND && sent_kinds.size() < RULE_SLOTS) begin
      val = req.rule_value;
      if (req.rule_kind == KIND_PROTO) val = {24'd0, val[7:0]};
      else if (req.rule_kind == KIND_PORT) val = {16'd0, val[15:0]};
      sent_kinds.push_back(req.rule_kind);
      sent_values.push_back(val);
    end
  endtask

  // Hold start low until every result has come back.
  // outstanding is registered from the queue size, so look only after the next edge.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Random request: mostly classify, with packets often aimed at a stored
  // rule so that matches, shadowing and hit counting get exercised.
  function automatic in_req_t random_request();
    in_req_t      req;
    logic [127:0] bits;
    int           pick;
    int           k;
    bits = {$urandom, $urandom, $urandom, $urandom};
    req  = bits[$bits(in_req_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      req.opcode       = OP_CLASSIFY;
      req.packet_valid = ($urandom_range(0, 9) != 0);
      if (sent_kinds.size() > 0 && $urandom_range(0, 2) != 0) begin
        k = $urandom_range(0, sent_kinds.size() - 1);
        case (sent_kinds[k])
          KIND_PROTO:  req.protocol  = sent_values[k][7:0];
          KIND_PORT:   req.dest_port = sent_values[k][15:0];
          KIND_SRC_IP: req.src_ip    = sent_values[k];
          default: ;
        endcase
      end
    end else if (pick < 72) begin
      req.opcode = OP_APPEND;
      // duplicates of earlier values test that the lower slot wins
      if (sent_kinds.size() > 0 && $urandom_range(0, 2) == 0) begin
        k = $urandom_range(0, sent_kinds.size() - 1);
        req.rule_value = sent_values[k];
        if ($urandom_range(0, 1)) req.rule_kind = sent_kinds[k];
      end
    end else if (pick < 95) begin
      req.opcode = OP_READ;
      if (sent_kinds.size() > 0 && $urandom_range(0, 3) != 0)
        req.rule_slot = 5'($urandom_range(0, sent_kinds.size() - 1));
    end else begin
      req.opcode = OP_UNUSED;
    end
    return req;
  endfunction

  initial begin
    in_req_t req;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_req  = '0;
    gaps_on = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed part ---
    // empty table: read out of range, classify finds nothing
    req = blank_request(OP_READ);
    issue(req);
    req = blank_request(OP_CLASSIFY);
    req.packet_valid = 1'b1;
    issue(req);
    // unknown opcode with every field at its maximum
    req = '1;
    req.opcode = OP_UNUSED;
    issue(req);

    // one rule of each kind; upper bits of protocol/port values must be cut off
    req = blank_request(OP_APPEND);
    req.rule_kind  = KIND_PROTO;
    req.rule_value = 32'hFFFF_FF06;
    issue(req);
    req = blank_request(OP_APPEND);
    req.rule_kind  = KIND_PORT;
    req.rule_value = 32'h1234_0050;
    issue(req);
    req = blank_request(OP_APPEND);
    req.rule_kind  = KIND_SRC_IP;
    req.rule_value = 32'hFFFF_FFFF;
    issue(req);
    // unknown kind: counted, never matches (value 0 would hit an all-zero packet)
    req = blank_request(OP_APPEND);
    req.rule_kind  = KIND_UNUSED;
    req.rule_value = 32'h0000_0000;
    issue(req);
    // duplicate of slot 0, always shadowed
    req = blank_request(OP_APPEND);
    req.rule_kind  = KIND_PROTO;
    req.rule_value = 32'h0000_0006;
    issue(req);

    // protocol hit on slot 0
    req = blank_request(OP_CLASSIFY);
    req.packet_valid = 1'b1;
    req.protocol     = 8'h06;
    issue(req);
    // same packet marked invalid: accepted, no count
    req.packet_valid = 1'b0;
    issue(req);
    // port hit
    req = blank_request(OP_CLASSIFY);
    req.packet_valid = 1'b1;
    req.protocol     = 8'h11;
    req.dest_port    = 16'h0050;
    issue(req);
    // source address hit, other fields at maximum
    req = blank_request(OP_CLASSIFY);
    req.packet_valid = 1'b1;
    req.protocol     = 8'hFF;
    req.dest_port    = 16'hFFFF;
    req.src_ip       = 32'hFFFF_FFFF;
    issue(req);
    // all-zero packet: no rule matches
    req = blank_request(OP_CLASSIFY);
    req.packet_valid = 1'b1;
    issue(req);
    // protocol and port both match: the lower slot wins
    req = blank_request(OP_CLASSIFY);
    req.packet_valid = 1'b1;
    req.protocol     = 8'h06;
    req.dest_port    = 16'h0050;
    issue(req);

    // hit counts, then reads at and past the end of the table
    req = blank_request(OP_READ);
    req.rule_slot = 5'd0;
    issue(req);
    req.rule_slot = 5'd4;
    issue(req);
    req.rule_slot = 5'd5;
    issue(req);
    req.rule_slot = 5'd31;
    issue(req);
    // unknown opcode carrying a matching packet changes nothing
    req = blank_request(OP_UNUSED);
    req.packet_valid = 1'b1;
    req.protocol     = 8'h06;
    issue(req);
    req = blank_request(OP_READ);
    req.rule_slot = 5'd0;
    issue(req);

    drain();

    // --- random part ---
    // idle gaps switch on and off in runs of 64 requests
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if (n == RANDOM_REQUESTS / 2) drain();
      issue(random_request());
    end

    drain();
    // settle time for anything strobed late
    repeat (RULE_SLOTS + 10) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
